FILE: design/uvsch_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvsch_pkg
// Shared types and constants for the daily UV exposure scheduler.
// ----------------------------------------------------------------------------
package uvsch_pkg;

  // Width of the day-time counter and of every timing register.
  localparam int unsigned TIME_BITS = 27;

  // Configuration port geometry.
  localparam int unsigned CFG_ADDR_BITS = 2;

  typedef logic [TIME_BITS-1:0]     time_t;
  typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;

  // Saturation value of the day-time counter.
  localparam time_t TIME_MAX = {TIME_BITS{1'b1}};

  // Register indexes.
  localparam cfg_addr_t REG_START_DELAY = 2'd0;
  localparam cfg_addr_t REG_ON_TIME     = 2'd1;
  localparam cfg_addr_t REG_DAY_PERIOD  = 2'd2;

  // Reset values of the timing registers, in milliseconds.
  localparam time_t START_DELAY_RST = TIME_BITS'(10000);
  localparam time_t ON_TIME_RST     = TIME_BITS'(5000);
  localparam time_t DAY_PERIOD_RST  = TIME_BITS'(30000);

  // Timing settings handed from the register file to the scheduler core.
  typedef struct packed {
    time_t start_delay;
    time_t on_time;
    time_t day_period;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic uv_drive;
    logic led_red;
    logic led_green;
    logic led_blue;
    logic run_done_today;
  } result_t;

endpackage
`default_nettype wire

FILE: design/daily_uv_exposure_scheduler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// daily_uv_exposure_scheduler_unit
// Daily UV exposure scheduler driven by one millisecond tick per item.
// ----------------------------------------------------------------------------
// Each input item is one millisecond tick with the lid switch level, and it
// yields exactly one result item with the UV drive enable, the three
// indicator LEDs and the done-today flag. For each accepted tick the
// day counter and run state update through one pass of compare logic, and
// the result enters a two-entry output buffer, so a new tick is accepted
// every cycle while the buffer has room; each result is registered there. The
// user must write the timing registers (start delay, on time, day period, in
// ticks) through the cfg port while the block is idle; it does not enforce it.
// ----------------------------------------------------------------------------
module daily_uv_exposure_scheduler_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire uvsch_pkg::cfg_addr_t cfg_addr,
  input  wire uvsch_pkg::time_t     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 lid_open,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      uv_drive,
  output logic                      led_red,
  output logic                      led_green,
  output logic                      led_blue,
  output logic                      run_done_today
);

  uvsch_pkg::cfg_t    cfg;
  uvsch_pkg::result_t result;
  uvsch_pkg::result_t head;
  logic               tick;

  assign tick = in_valid && in_ready;

  uvsch_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  uvsch_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .tick     (tick),
    .lid_open (lid_open),
    .result   (result)
  );

  uvsch_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (tick),
    .push_data (result),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Result fields to ports.
  assign uv_drive       = head.uv_drive;
  assign led_red        = head.led_red;
  assign led_green      = head.led_green;
  assign led_blue       = head.led_blue;
  assign run_done_today = head.run_done_today;

endmodule
`default_nettype wire

FILE: design/uvsch_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvsch_cfg_regs
// Timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
module uvsch_cfg_regs (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire uvsch_pkg::cfg_addr_t cfg_addr,
  input  wire uvsch_pkg::time_t     cfg_wdata,
  output uvsch_pkg::cfg_t           cfg
);

  // Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delay <= uvsch_pkg::START_DELAY_RST;
      cfg.on_time     <= uvsch_pkg::ON_TIME_RST;
      cfg.day_period  <= uvsch_pkg::DAY_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        uvsch_pkg::REG_START_DELAY: cfg.start_delay <= cfg_wdata;
        uvsch_pkg::REG_ON_TIME:     cfg.on_time     <= cfg_wdata;
        uvsch_pkg::REG_DAY_PERIOD:  cfg.day_period  <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/uvsch_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvsch_core
// Day counter and exposure run state; computes one result per tick.
// ----------------------------------------------------------------------------
module uvsch_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire uvsch_pkg::cfg_t   cfg,
  input  wire logic              tick,
  input  wire logic              lid_open,
  output uvsch_pkg::result_t     result
);

  uvsch_pkg::time_t day_count, day_count_next;
  uvsch_pkg::time_t run_start, run_start_next;
  logic             run_active, run_active_next;
  logic             run_finished, run_finished_next;

  uvsch_pkg::time_t now;
  uvsch_pkg::time_t elapsed;
  logic             day_wrap;

  // Next state for one tick.
  always_comb begin
    day_wrap          = (day_count >= cfg.day_period);
    now               = day_wrap ? '0 : day_count;
    run_active_next   = day_wrap ? 1'b0 : run_active;
    run_finished_next = day_wrap ? 1'b0 : run_finished;
    run_start_next    = run_start;

    if ((now >= cfg.start_delay) && !run_finished_next) begin
      if (!run_active_next) begin
        run_active_next = 1'b1;
        run_start_next  = now;
      end
    end
    elapsed = now - run_start_next;
    if ((now >= cfg.start_delay) && !run_finished_next &&
        (elapsed >= cfg.on_time)) begin
      run_active_next   = 1'b0;
      run_finished_next = 1'b1;
    end

    // The counter saturates rather than wraps.
    day_count_next = (now < uvsch_pkg::TIME_MAX) ? now + 1'b1 : uvsch_pkg::TIME_MAX;
  end

  // Result after the state update; an open lid forces the drive off.
  always_comb begin
    result.uv_drive       = run_active_next && !lid_open;
    result.led_red        = lid_open;
    result.led_green      = !run_active_next && !lid_open;
    result.led_blue       = run_active_next && !lid_open;
    result.run_done_today = run_finished_next;
  end

  // State registers advance once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      day_count    <= '0;
      run_start    <= '0;
      run_active   <= 1'b0;
      run_finished <= 1'b0;
    end else if (tick) begin
      day_count    <= day_count_next;
      run_start    <= run_start_next;
      run_active   <= run_active_next;
      run_finished <= run_finished_next;
    end
  end

`ifndef ASSERT_OFF
  // A run is never active once it has been marked done for the day.
  a_active_xor_done: assert property (@(posedge clk) disable iff (rst)
    !(run_active && run_finished))
    else $error("run active and finished at once");
`endif

endmodule
`default_nettype wire

FILE: design/uvsch_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvsch_out_buf
// Two-entry result buffer that decouples the input side from output stalls.
// ----------------------------------------------------------------------------
module uvsch_out_buf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire uvsch_pkg::result_t push_data,
  output logic                    has_room,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output uvsch_pkg::result_t      head
);

  uvsch_pkg::result_t slot0, slot1;
  logic [1:0]         count;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign has_room  = (count != 2'd2);
  assign head      = slot0;

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // Payload slots; slot0 is always the head.
  always_ff @(posedge clk) begin
    if (pop && !push) begin
      slot0 <= slot1;
    end else if (push && !pop) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end else if (push && pop) begin
      if (count == 2'd1) begin
        slot0 <= push_data;
      end else begin
        slot0 <= slot1;
        slot1 <= push_data;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("push without pop did not grow the buffer");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 2'd1))
    else $error("pop without push did not shrink the buffer");
`endif

endmodule
`default_nettype wire

FILE: bench/daily_uv_exposure_scheduler_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// daily_uv_exposure_scheduler_unit_tb
// Self-checking bench for the daily UV exposure scheduler.
// ----------------------------------------------------------------------------
// Ticks carrying the lid level are offered on the input channel, and every
// accepted tick is run through a scheduler model in the bench that predicts
// the drive, indicator and done-today bits. Each result item is compared
// against the oldest prediction. A short directed part covers reset timing,
// a run starting with the lid open, zero on time, a zero day period and the
// register extremes. It is followed by randomized phases with fresh timing
// settings, bursty idling on both channels, and one long output stall.
// ----------------------------------------------------------------------------
module daily_uv_exposure_scheduler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it; writes to it must be ignored.
  localparam uvsch_pkg::cfg_addr_t REG_UNUSED = 2'd3;

  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_TICKS   = 50;
  localparam int unsigned CALM_FROM     = 460;
  localparam int unsigned SQUEEZE_AT    = 200;
  localparam int unsigned HOLD_CYCLES   = 48;
  localparam int unsigned CYCLE_LIMIT   = 100000;

  // Scheduler model and queue of predicted result items.
  class uv_schedule_book;
    uvsch_pkg::time_t   start_delay;
    uvsch_pkg::time_t   on_time;
    uvsch_pkg::time_t   day_period;
    uvsch_pkg::time_t   day_count;
    uvsch_pkg::time_t   run_start;
    bit                 run_active;
    bit                 run_finished;
    uvsch_pkg::result_t predicted_q[$];
    int unsigned        fails;

    function new();
      start_delay  = uvsch_pkg::START_DELAY_RST;
      on_time      = uvsch_pkg::ON_TIME_RST;
      day_period   = uvsch_pkg::DAY_PERIOD_RST;
      day_count    = '0;
      run_start    = '0;
      run_active   = 1'b0;
      run_finished = 1'b0;
      fails        = 0;
    endfunction

    function void set_reg(uvsch_pkg::cfg_addr_t idx, uvsch_pkg::time_t value);
      case (idx)
        uvsch_pkg::REG_START_DELAY: start_delay = value;
        uvsch_pkg::REG_ON_TIME:     on_time = value;
        uvsch_pkg::REG_DAY_PERIOD:  day_period = value;
        default: ;
      endcase
    endfunction

    // Advance the schedule by one tick and predict its result item.
    function void note_tick(logic lid);
      uvsch_pkg::time_t   now;
      uvsch_pkg::result_t r;
      now = day_count;
      if (now >= day_period) begin
        now          = '0;
        run_active   = 1'b0;
        run_finished = 1'b0;
      end
      if (now >= start_delay && !run_finished) begin
        if (!run_active) begin
          run_active = 1'b1;
          run_start  = now;
        end
        if (uvsch_pkg::time_t'(now - run_start) >= on_time) begin
          run_active   = 1'b0;
          run_finished = 1'b1;
        end
      end
      day_count        = (now < uvsch_pkg::TIME_MAX) ?
                         uvsch_pkg::time_t'(now + 1'b1) : uvsch_pkg::TIME_MAX;
      r.uv_drive       = run_active && !lid;
      r.led_red        = lid;
      r.led_green      = !run_active && !lid;
      r.led_blue       = run_active && !lid;
      r.run_done_today = run_finished;
      predicted_q.push_back(r);
    endfunction

    function void check_result(uvsch_pkg::result_t got);
      uvsch_pkg::result_t want;
      logic [4:0]         w;
      logic [4:0]         g;
      string              field_names [5] = '{"uv_drive", "led_red", "led_green",
                                              "led_blue", "run_done_today"};
      if (predicted_q.size() == 0) begin
        $error("result item arrived with no tick waiting");
        fails++;
        return;
      end
      want = predicted_q.pop_front();
      w = want;
      g = got;
      for (int i = 0; i < 5; i++) begin
        if (w[4-i] !== g[4-i]) begin
          $error("%s: expected %0b, got %0b", field_names[i], w[4-i], g[4-i]);
          fails++;
        end
      end
    endfunction

    function int unsigned pending();
      return predicted_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  uvsch_pkg::cfg_addr_t cfg_addr;
  uvsch_pkg::time_t     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 lid_open;
  logic                 out_valid;
  logic                 out_ready;
  logic                 uv_drive;
  logic                 led_red;
  logic                 led_green;
  logic                 led_blue;
  logic                 run_done_today;

  uv_schedule_book    book;
  uvsch_pkg::result_t seen;
  int unsigned        accepted_ticks = 0;
  int unsigned        cycle_count = 0;
  bit                 squeezed;

  daily_uv_exposure_scheduler_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .lid_open       (lid_open),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .uv_drive       (uv_drive),
    .led_red        (led_red),
    .led_green      (led_green),
    .led_blue       (led_blue),
    .run_done_today (run_done_today)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("daily_uv_exposure_scheduler_unit: mismatch");
      $finish;
    end
  end

  // Both handshakes are sampled here, input first, so a tick is always
  // predicted before its result could be checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        book.note_tick(lid_open);
        accepted_ticks <= accepted_ticks + 1;
      end
      if (out_valid && out_ready) begin
        seen = {uv_drive, led_red, led_green, led_blue, run_done_today};
        book.check_result(seen);
      end
    end
  end

  // Result receiver: random stall bursts, one long hold-off, calm at the end.
  initial begin
    out_ready = 1'b0;
    squeezed  = 1'b0;
    @(negedge clk);
    forever begin
      if (!squeezed && accepted_ticks >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (accepted_ticks < CALM_FROM && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Offer one tick and hold it until accepted; maybe idle afterwards.
  // Called and returns at a falling edge.
  task automatic send_tick(input logic lid);
    in_valid <= 1'b1;
    lid_open <= lid;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (accepted_ticks < CALM_FROM && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      lid_open <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Stop offering and wait for every predicted result to come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (book.pending() != 0);
    repeat (2) @(negedge clk);
  endtask

  // Write all three timing registers plus the unused index, back to back.
  task automatic apply_setting(input uvsch_pkg::time_t sd, input uvsch_pkg::time_t ot,
                               input uvsch_pkg::time_t dp);
    uvsch_pkg::time_t junk;
    junk = uvsch_pkg::time_t'($urandom);
    cfg_we    <= 1'b1;
    cfg_addr  <= uvsch_pkg::REG_START_DELAY;
    cfg_wdata <= sd;
    book.set_reg(uvsch_pkg::REG_START_DELAY, sd);
    @(negedge clk);
    cfg_addr  <= uvsch_pkg::REG_ON_TIME;
    cfg_wdata <= ot;
    book.set_reg(uvsch_pkg::REG_ON_TIME, ot);
    @(negedge clk);
    cfg_addr  <= uvsch_pkg::REG_DAY_PERIOD;
    cfg_wdata <= dp;
    book.set_reg(uvsch_pkg::REG_DAY_PERIOD, dp);
    @(negedge clk);
    cfg_addr  <= REG_UNUSED;
    cfg_wdata <= junk;
    book.set_reg(REG_UNUSED, junk);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Main stimulus.
  initial begin
    uvsch_pkg::time_t sd;
    uvsch_pkg::time_t ot;
    uvsch_pkg::time_t dp;
    logic             lid;
    book      = new();
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_addr  = uvsch_pkg::REG_START_DELAY;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    lid_open  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset timing, lid closed then open.
    send_tick(1'b0);
    send_tick(1'b1);
    drain();

    // Short day; the counter is at 2, so the first tick starts a run with
    // the lid open.
    apply_setting(27'd2, 27'd3, 27'd8);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    // Zero on time: the run starts and ends on one tick.
    apply_setting(27'd1, 27'd0, 27'd4);
    repeat (5) send_tick(1'b0);
    drain();

    // Zero day period: the day restarts on every tick.
    apply_setting(27'd0, 27'd2, 27'd0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();

    // Register extremes.
    apply_setting(27'd0, uvsch_pkg::TIME_MAX, uvsch_pkg::TIME_MAX);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();
    apply_setting(uvsch_pkg::TIME_MAX, 27'd0, uvsch_pkg::TIME_MAX);
    send_tick(1'b0);
    send_tick(1'b1);
    drain();

    // Random phases: short days so that runs happen often, now and then an
    // extreme register value. The lid is mostly closed, open in short spells.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      sd = uvsch_pkg::time_t'($urandom_range(0, 12));
      ot = uvsch_pkg::time_t'($urandom_range(0, 10));
      dp = uvsch_pkg::time_t'($urandom_range(1, 30));
      case ($urandom_range(0, 6))
        0: ot = uvsch_pkg::TIME_MAX;
        1: sd = uvsch_pkg::TIME_MAX;
        2: dp = uvsch_pkg::time_t'($urandom);
        3: ot = '0;
        default: ;
      endcase
      apply_setting(sd, ot, dp);
      lid = 1'b0;
      for (int k = 0; k < PHASE_TICKS; k++) begin
        if (lid) lid = ($urandom_range(0, 2) != 0);
        else     lid = ($urandom_range(0, 7) == 0);
        send_tick(lid);
      end
      drain();
    end

    repeat (8) @(negedge clk);
    if (book.fails == 0 && book.pending() == 0) begin
      $display("daily_uv_exposure_scheduler_unit: match");
    end else begin
      $display("daily_uv_exposure_scheduler_unit: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
